// File: rtl/sbdp_pkg.sv
// ----------------------------------------------------------------------------
// sbdp_pkg: shared types and constants
// Item layouts, fixed-point limits and the CORDIC angle table.
// ----------------------------------------------------------------------------
package sbdp_pkg;

  localparam int unsigned MaxSamples  = 65536;
  localparam int unsigned CntW        = 17;
  localparam int unsigned AccW        = 50;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicCntW  = 5;
  localparam int unsigned CorW        = 34;
  localparam int unsigned TrigW       = 18;
  localparam int unsigned ProdW       = 34;
  localparam int unsigned DivW        = 51;
  localparam int unsigned DivCntW     = 6;
  localparam int unsigned RootSteps   = 32;
  localparam int unsigned RootCntW    = 5;
  localparam logic [CorW-1:0] GainQ30 = CorW'(652032874);

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] sample_value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [47:0] power;
    logic [31:0] amplitude;
    logic        empty_frame;
  } out_t;

  function automatic logic [31:0] angle_turns(input logic [CordicCntW-1:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41721;
      5'd15:   a = 32'd20860;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2607;
      5'd19:   a = 32'd1303;
      5'd20:   a = 32'd651;
      5'd21:   a = 32'd325;
      5'd22:   a = 32'd162;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/sbdp_fifo.sv
// ----------------------------------------------------------------------------
// sbdp_fifo: front queue
// Two-entry queue that takes input items and hands them to the back end.
// ----------------------------------------------------------------------------
module sbdp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbdp_pkg::in_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sbdp_pkg::in_t pop_data_o
);
  import sbdp_pkg::*;

  in_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/sbdp_cordic.sv
// ----------------------------------------------------------------------------
// sbdp_cordic: iterative rotation CORDIC
// One step per cycle; yields Q16 cosine and sine of a phase in turns.
// ----------------------------------------------------------------------------
module sbdp_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [31:0]                        phase_i,
  output logic                               done_o,
  output logic signed [sbdp_pkg::TrigW-1:0]  cos_o,
  output logic signed [sbdp_pkg::TrigW-1:0]  sin_o
);
  import sbdp_pkg::*;

  logic signed [CorW-1:0] x_q, y_q, z_q, dx, dy, ang;
  logic [CordicCntW-1:0]  cnt_q;
  logic [1:0]             quad_q;
  logic                   busy_q, done_q;
  logic signed [TrigW-1:0] xr, yr;

  function automatic logic signed [TrigW-1:0] to_q16(input logic signed [CorW-1:0] v);
    logic signed [CorW-1:0] r;
    r = (v + CorW'(8192)) >>> 14;
    if (r > CorW'(65536)) begin
      r = CorW'(65536);
    end else if (r < -CorW'(65536)) begin
      r = -CorW'(65536);
    end
    return r[TrigW-1:0];
  endfunction

  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign ang = $signed({{(CorW-32){1'b0}}, angle_turns(cnt_q)});
  assign xr  = to_q16(x_q);
  assign yr  = to_q16(y_q);

  always_comb begin
    unique case (quad_q)
      2'd0:    begin cos_o = xr;  sin_o = yr;  end
      2'd1:    begin cos_o = -yr; sin_o = xr;  end
      2'd2:    begin cos_o = -xr; sin_o = -yr; end
      default: begin cos_o = yr;  sin_o = -xr; end
    endcase
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quad_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= GainQ30;
        y_q    <= '0;
        z_q    <= $signed({{(CorW-30){1'b0}}, phase_i[29:0]});
        quad_q <= phase_i[31:30];
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!z_q[CorW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - ang;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + ang;
        end
        if (cnt_q == CordicCntW'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/sbdp_back.sv
// ----------------------------------------------------------------------------
// sbdp_back: accumulate and frame-end arithmetic
// Phase, CORDIC, accumulation; on frame end divide, square and root.
// ----------------------------------------------------------------------------
module sbdp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           empty_i,
  input  sbdp_pkg::in_t  item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sbdp_pkg::out_t out_data_o
);
  import sbdp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_CORD, S_ACC, S_CHECK, S_DIV, S_SQC, S_SQS, S_ROOT, S_FINISH
  } state_e;

  state_e                  state_q;
  logic [31:0]             freq_q, phase_q;
  logic                    last_q, empty_q, out_valid_q;
  logic signed [15:0]      val_q;
  logic signed [ProdW-1:0] prod_c_q, prod_s_q;
  logic signed [AccW-1:0]  acc_c_q, acc_s_q, sat_c, sat_s;
  logic [CntW-1:0]         cnt_q, dvs_q;
  logic [DivW-1:0]         div_c_q, div_s_q, mag_c, mag_s;
  logic [CntW-1:0]         rem_c_q, rem_s_q;
  logic [DivCntW-1:0]      dstep_q;
  logic [31:0]             mc_q, ms_q, mc_d, ms_d;
  logic [63:0]             sq_q, sqv_q, res_q, bit_q, sq_sum, trial;
  logic [RootCntW-1:0]     sstep_q;
  logic [63:0]             phase_full;
  logic [63:0]             pwr;
  logic                    cord_done;
  logic signed [TrigW-1:0] cos_w, sin_w;
  logic [CntW+DivW-1:0]    dc, ds;
  out_t                    out_q;

  function automatic logic [CntW+DivW-1:0] div_step(input logic [CntW-1:0] rem,
                                                   input logic [DivW-1:0] dvd,
                                                   input logic [CntW-1:0] dvs);
    logic [CntW:0]   t;
    logic [CntW-1:0] r;
    logic            qb;
    t = {rem, dvd[DivW-1]};
    if (t >= {1'b0, dvs}) begin
      r  = CntW'(t - {1'b0, dvs});
      qb = 1'b1;
    end else begin
      r  = t[CntW-1:0];
      qb = 1'b0;
    end
    return {r, dvd[DivW-2:0], qb};
  endfunction

  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                     input logic signed [ProdW-1:0] p);
    logic signed [AccW:0] s;
    logic signed [AccW-1:0] r;
    s = {a[AccW-1], a} + {{(AccW+1-ProdW){p[ProdW-1]}}, p};
    if (s[AccW] != s[AccW-1]) begin
      r = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = s[AccW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DivW-1:0] mag_round(input logic signed [AccW-1:0] a,
                                                input logic [CntW-1:0] n);
    logic [DivW-1:0] e;
    e = {a[AccW-1], a};
    if (a[AccW-1]) e = ~e + 1'b1;
    return e + DivW'(n >> 1);
  endfunction

  function automatic logic [31:0] clamp_mean(input logic [DivW-1:0] q);
    logic [31:0] r;
    if ((|q[DivW-1:32]) || (q[31] && (|q[30:0]))) begin
      r = 32'h8000_0000;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

  sbdp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PHASE),
    .phase_i (phase_q),
    .done_o  (cord_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign phase_full  = {32'd0, freq_q} * {32'd0, item_i.sample_time};
  assign sat_c       = sat_add(acc_c_q, prod_c_q);
  assign sat_s       = sat_add(acc_s_q, prod_s_q);
  assign mag_c       = mag_round(acc_c_q, cnt_q);
  assign mag_s       = mag_round(acc_s_q, cnt_q);
  assign dc          = div_step(rem_c_q, div_c_q, dvs_q);
  assign ds          = div_step(rem_s_q, div_s_q, dvs_q);
  assign mc_d        = clamp_mean(div_c_q);
  assign ms_d        = clamp_mean(div_s_q);
  assign sq_sum      = sq_q + {32'd0, ms_q} * {32'd0, ms_q};
  assign trial       = res_q + bit_q;
  assign pwr         = sq_q + 64'd32768;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        val_q   <= item_i.sample_value;
        last_q  <= item_i.last;
        phase_q <= phase_full[31:0];
      end
      S_CORD: begin
        prod_c_q <= val_q * cos_w;
        prod_s_q <= val_q * sin_w;
      end
      S_CHECK: begin
        div_c_q <= mag_c;
        div_s_q <= mag_s;
        rem_c_q <= '0;
        rem_s_q <= '0;
        dvs_q   <= cnt_q;
        dstep_q <= '0;
      end
      S_DIV: begin
        rem_c_q <= dc[CntW+DivW-1:DivW];
        div_c_q <= dc[DivW-1:0];
        rem_s_q <= ds[CntW+DivW-1:DivW];
        div_s_q <= ds[DivW-1:0];
        dstep_q <= dstep_q + 1'b1;
        mc_q    <= mc_d;
        ms_q    <= ms_d;
      end
      S_SQC: begin
        sq_q <= {32'd0, mc_q} * {32'd0, mc_q};
      end
      S_SQS: begin
        sq_q    <= sq_sum;
        sqv_q   <= sq_sum;
        res_q   <= '0;
        bit_q   <= 64'h4000_0000_0000_0000;
        sstep_q <= '0;
      end
      S_ROOT: begin
        if (sqv_q >= trial) begin
          sqv_q <= sqv_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q   <= bit_q >> 2;
        sstep_q <= sstep_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      freq_q      <= '0;
      acc_c_q     <= '0;
      acc_s_q     <= '0;
      cnt_q       <= '0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) freq_q <= cfg_data_i;
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            state_q <= (cnt_q < CntW'(MaxSamples)) ? S_PHASE : S_CHECK;
          end
        end
        S_PHASE: state_q <= S_CORD;
        S_CORD:  if (cord_done) state_q <= S_ACC;
        S_ACC: begin
          acc_c_q <= sat_c;
          acc_s_q <= sat_s;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            empty_q <= (cnt_q == '0);
            state_q <= (cnt_q == '0) ? S_FINISH : S_DIV;
            acc_c_q <= '0;
            acc_s_q <= '0;
            cnt_q   <= '0;
          end
        end
        S_DIV:  if (dstep_q == DivCntW'(DivW)) state_q <= S_SQC;
        S_SQC:  state_q <= S_SQS;
        S_SQS:  state_q <= S_ROOT;
        S_ROOT: if (sstep_q == RootCntW'(RootSteps - 1)) state_q <= S_FINISH;
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            if (empty_q) begin
              out_q <= '{power: '0, amplitude: '0, empty_frame: 1'b1};
            end else begin
              out_q <= '{power: pwr[63:16], amplitude: res_q[31:0], empty_frame: 1'b0};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/single_bin_dft_power.sv
// ----------------------------------------------------------------------------
// single_bin_dft_power: one DFT bin power and amplitude
// Top level: front queue plus the accumulate and frame-end back end.
// ----------------------------------------------------------------------------
// Usage:
//   Write the analysis frequency (Q16.16 Hz) through cfg_we_i/cfg_data_i while
//   the block is idle. Send items on in_valid_i/in_data_i; an item is taken
//   when in_stall_o is low. A two-entry queue absorbs items while the back end
//   works. Each counted item passes in the back end through the pop, the phase
//   multiply, 16 CORDIC steps, the accumulate and the last-mark check. An item
//   with the last mark also runs a restoring divide, the squaring of both means
//   and a bit-by-bit square root before its frame result goes to the output.
//   Results leave on out_valid_o/out_data_o through an output register; while
//   out_stall_i holds it, the result stays put and the back end stops only
//   when it has a second result ready.
//   Reset clears the frequency, the sums, the count and both handshakes.
// ----------------------------------------------------------------------------
module single_bin_dft_power (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sbdp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sbdp_pkg::out_t out_data_o
);
  import sbdp_pkg::*;

  logic full, empty, pop;
  in_t  item;

  assign in_stall_o = full;

  sbdp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (in_data_i),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (item)
  );

  sbdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (empty),
    .item_i      (item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/sbdp_checker.sv
// ----------------------------------------------------------------------------
// sbdp_checker: port-level checks
// Watches the top level ports; bound to single_bin_dft_power.
// ----------------------------------------------------------------------------
module sbdp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sbdp_pkg::out_t out_data_o
);
  import sbdp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_frame |->
      out_data_o.power == 48'd0 && out_data_o.amplitude == 32'd0)
    else $error("empty frame with nonzero result");

  a_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.amplitude <= 32'd3037000500)
    else $error("amplitude out of range");

endmodule

bind single_bin_dft_power sbdp_checker u_sbdp_checker (.*);
